// File: src/gcdu_pkg.sv
// shared types and constants for the gcd / lcm / modular inverse unit
`default_nettype none
package gcdu_pkg;

  localparam int DEF_OPERAND_WIDTH = 32;
  localparam int IN_WIDTH          = 32;
  localparam int RESULT_WIDTH      = 64;

  typedef enum logic [1:0] {
    F_GCD = 2'd0,
    F_LCM = 2'd1,
    F_INV = 2'd2,
    F_NOP = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_SUB,
    S_REM,
    S_LCM_DIV,
    S_LCM_MUL,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// File: src/integer_gcd_lcm_modinv_unit.sv
// top level: gcd, lcm and modular inverse over one shared serial divider
// usage:
//   input channel  in_valid / in_stall carries func, operand_a, operand_b
//   output channel out_valid / out_stall carries result_value, no_inverse
//   one result beat per input beat, in order
//   only the low OPERAND_WIDTH bits of each operand are used, sign extended
// sequence:
//   every euclid step is one check state plus one pass through the shared
//   restoring divider of OPERAND_WIDTH+1 bits, ended by its done strobe;
//   the inverse adds a multiply and a subtract state; lcm and inverse add
//   one more divider pass at the end; at most about 47 steps at 32 bits
//   one item is in flight at a time: in_stall is high while it is worked,
//   the next beat can be taken in the cycle after the result is registered
// reset: rst is synchronous, clears the sequencer and the output valid
// receiver stall: a finished result is held in the output register; the
//   next item may be taken while it waits, but that item cannot finish
//   until the held beat is taken
`default_nettype none
module integer_gcd_lcm_modinv_unit #(
  parameter int OPERAND_WIDTH = gcdu_pkg::DEF_OPERAND_WIDTH
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic [1:0]                               func,
  input  wire logic signed [gcdu_pkg::IN_WIDTH-1:0]     operand_a,
  input  wire logic signed [gcdu_pkg::IN_WIDTH-1:0]     operand_b,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic signed [gcdu_pkg::RESULT_WIDTH-1:0]      result_value,
  output logic                                          no_inverse
);
  import gcdu_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int N  = W + 1;        // magnitude width
  localparam int SW = W + 2;        // coefficient width

  state_t state, state_next;
  func_t  fn, fn_next;

  // remainder pair: magnitudes for gcd/lcm, signed values for inverse
  logic signed [N-1:0]  r0, r0_next, r1, r1_next;
  logic signed [SW-1:0] s0, s0_next, s1, s1_next;
  logic signed [SW-1:0] q, q_next, prod, prod_next;
  logic [N-1:0]         am, am_next, bm, bm_next;
  logic signed [N-1:0]  bs, bs_next;
  logic [N-1:0]         lq, lq_next;
  logic signed [RESULT_WIDTH-1:0] res, res_next;
  logic                 flag, flag_next;

  // divider hookup
  logic          div_start;
  logic [N-1:0]  div_num, div_den, div_quot, div_rem;
  logic          div_done;

  // operand decode
  logic signed [N-1:0] a_ext, b_ext;
  logic [N-1:0]        a_mag, b_mag;
  logic [N-1:0]        r0_mag, r1_mag, s0_mag;
  logic signed [SW-1:0] qs;
  logic signed [N-1:0]  rem_s, fin;
  logic [2*N-1:0]       lcm_prod;
  logic                 out_free;

  assign a_ext  = {operand_a[W-1], operand_a[W-1:0]};
  assign b_ext  = {operand_b[W-1], operand_b[W-1:0]};
  assign a_mag  = a_ext[N-1] ? N'(-a_ext) : N'(a_ext);
  assign b_mag  = b_ext[N-1] ? N'(-b_ext) : N'(b_ext);
  assign r0_mag = r0[N-1] ? N'(-r0) : N'(r0);
  assign r1_mag = r1[N-1] ? N'(-r1) : N'(r1);
  assign s0_mag = s0[SW-1] ? N'(-s0) : N'(s0);
  assign out_free = !out_valid || !out_stall;

  // truncating quotient sign: negative when operand signs differ
  assign qs    = (r0[N-1] ^ r1[N-1]) ? -SW'(div_quot) : SW'(div_quot);
  assign rem_s = $signed(div_rem);
  assign lcm_prod = lq * bm;

  assign in_stall = (state != S_IDLE);

  gcdu_div #(.WIDTH(N)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    fn   <= fn_next;
    r0   <= r0_next;
    r1   <= r1_next;
    s0   <= s0_next;
    s1   <= s1_next;
    q    <= q_next;
    prod <= prod_next;
    am   <= am_next;
    bm   <= bm_next;
    bs   <= bs_next;
    lq   <= lq_next;
    res  <= res_next;
    flag <= flag_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      result_value <= res;
      no_inverse   <= flag;
    end
  end

  always_comb begin
    state_next = state;
    fn_next    = fn;
    r0_next    = r0;
    r1_next    = r1;
    s0_next    = s0;
    s1_next    = s1;
    q_next     = q;
    prod_next  = prod;
    am_next    = am;
    bm_next    = bm;
    bs_next    = bs;
    lq_next    = lq;
    res_next   = res;
    flag_next  = flag;
    div_start  = 1'b0;
    div_num    = r0_mag;
    div_den    = r1_mag;
    fin        = rem_s;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          fn_next   = func_t'(func);
          am_next   = a_mag;
          bm_next   = b_mag;
          bs_next   = b_ext;
          s0_next   = SW'(1);
          s1_next   = '0;
          res_next  = '0;
          flag_next = 1'b0;
          if (func_t'(func) == F_INV) begin
            r0_next = a_ext;
            r1_next = b_ext;
          end else begin
            r0_next = $signed(a_mag);
            r1_next = $signed(b_mag);
          end
          state_next = (func_t'(func) == F_NOP) ? S_FINISH : S_CHECK;
        end
      end
      S_CHECK: begin
        if (r1 == '0) begin
          unique case (fn)
            F_GCD: begin
              res_next   = RESULT_WIDTH'(r0_mag);
              state_next = S_FINISH;
            end
            F_LCM: begin
              if (am == '0 || bm == '0) begin
                state_next = S_FINISH;
              end else begin
                // g divides a, so lcm = (|a| / g) * |b|
                div_start  = 1'b1;
                div_num    = am;
                div_den    = r0_mag;
                state_next = S_LCM_DIV;
              end
            end
            F_INV: begin
              if (bs == '0 || r0 != N'(1)) begin
                flag_next  = 1'b1;
                state_next = S_FINISH;
              end else begin
                div_start  = 1'b1;
                div_num    = s0_mag;
                div_den    = bm;
                state_next = S_REM;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_next     = qs;
          r0_next    = r1;
          r1_next    = r0[N-1] ? -rem_s : rem_s;
          state_next = (fn == F_INV) ? S_MUL : S_CHECK;
        end
      end
      S_MUL: begin
        prod_next  = q * s1;
        state_next = S_SUB;
      end
      S_SUB: begin
        s0_next    = s1;
        s1_next    = s0 - prod;
        state_next = S_CHECK;
      end
      S_REM: begin
        if (div_done) begin
          // truncating remainder, lifted once by m when negative
          fin = s0[SW-1] ? -rem_s : rem_s;
          if (fin[N-1]) begin
            fin = fin + bs;
          end
          res_next   = RESULT_WIDTH'(fin);
          state_next = S_FINISH;
        end
      end
      S_LCM_DIV: begin
        if (div_done) begin
          lq_next    = div_quot;
          state_next = S_LCM_MUL;
        end
      end
      S_LCM_MUL: begin
        res_next   = $signed(RESULT_WIDTH'(lcm_prod));
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a missing inverse always reads as zero
  a_noinv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_inverse |-> result_value == '0)
    else $error("no_inverse with nonzero result");
  // an accepted beat starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted beat dropped");
  // the divider is only waited on after it was started
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_DIV) |-> $past(div_start))
    else $error("divider wait without start");

endmodule
`default_nettype wire

// File: src/gcdu_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module gcdu_div #(
  parameter int WIDTH = gcdu_pkg::DEF_OPERAND_WIDTH + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] num,
  input  wire logic [WIDTH-1:0] den,
  output logic                  done,
  output logic [WIDTH-1:0]      quot,
  output logic [WIDTH-1:0]      rem
);
  import gcdu_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem, quot[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dvs  <= den;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem  <= diff[WIDTH-1:0];
        quot <= {quot[WIDTH-2:0], 1'b1};
      end else begin
        rem  <= trial[WIDTH-1:0];
        quot <= {quot[WIDTH-2:0], 1'b0};
      end
    end
  end

  // divisor is never zero when a division is launched
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst) start |-> den != '0)
    else $error("division by zero launched");
  // remainder stays below divisor at completion
  a_rem_lt_den: assert property (@(posedge clk) disable iff (rst) done |-> rem < dvs)
    else $error("remainder not below divisor");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("division started while busy");

endmodule
`default_nettype wire

// File: tb/sv/tb_integer_gcd_lcm_modinv_unit.sv
// self-checking testbench for the gcd / lcm / modular inverse unit
`timescale 1ns / 100ps
`default_nettype none
module tb_integer_gcd_lcm_modinv_unit;
  import gcdu_pkg::*;

  typedef struct packed {
    logic [1:0]   fn;
    logic [31:0]  a;
    logic [31:0]  b;
  } op_beat_t;

  typedef struct packed {
    logic [63:0] value;
    logic        flag;
  } answer_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int N_RANDOM       = 350;
  localparam int DRAIN_CYCLES   = 2000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  wire               in_stall;
  logic [1:0]        func;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  wire               out_valid;
  logic              out_stall;
  wire signed [63:0] result_value;
  wire               no_inverse;

  integer_gcd_lcm_modinv_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .no_inverse(no_inverse)
  );

  op_beat_t pending_ops[$];
  answer_t  expected_answers[$];
  int       errors;
  int       quiet_cycles;
  bit       feed_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // unsigned magnitude gcd
  function automatic logic [63:0] gcd_of(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // expected answer for one beat, truncating signed division throughout
  function automatic answer_t predict_answer(input op_beat_t op);
    answer_t ans;
    longint  a, b, r0, r1, s0, s1, q, nr, ns, rr;
    logic [63:0] g;
    a = longint'($signed(op.a));
    b = longint'($signed(op.b));
    ans = '0;
    case (func_t'(op.fn))
      F_GCD: ans.value = gcd_of(abs64(a), abs64(b));
      F_LCM: begin
        if (a != 0 && b != 0) begin
          g = gcd_of(abs64(a), abs64(b));
          ans.value = (abs64(a) * abs64(b)) / g;
        end
      end
      F_INV: begin
        if (b == 0) begin
          ans.flag = 1'b1;
        end else begin
          r0 = a; r1 = b; s0 = 1; s1 = 0;
          while (r1 != 0) begin
            q  = r0 / r1;
            nr = r0 % r1;
            ns = s0 - q * s1;
            r0 = r1; r1 = nr; s0 = s1; s1 = ns;
          end
          if (r0 != 1) begin
            ans.flag = 1'b1;
          end else begin
            rr = s0 % b;
            if (rr < 0) rr = rr + b;
            ans.value = 64'(rr);
          end
        end
      end
      default: ans = '0;
    endcase
    return ans;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 1000);
      2: return -$urandom_range(1, 100000);
      3: return $urandom;
      4: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
      default: return $urandom_range(0, 65535) * $urandom_range(1, 97);
    endcase
  endfunction

  task automatic push_op(input func_t f, input logic [31:0] a, input logic [31:0] b);
    pending_ops.push_back(op_beat_t'{fn: f, a: a, b: b});
  endtask

  // stimulus: directed corners then random content
  initial begin
    logic [31:0] a, b, k;
    push_op(F_GCD, 0, 0);
    push_op(F_GCD, 32'h8000_0000, 32'h8000_0000);
    push_op(F_GCD, 32'h7fff_ffff, 32'h8000_0000);
    push_op(F_GCD, 1836311903, 1134903170);          // fibonacci pair, most steps
    push_op(F_GCD, -48, 18);
    push_op(F_GCD, 0, -7);
    push_op(F_LCM, 0, 5);
    push_op(F_LCM, 7, 0);
    push_op(F_LCM, 32'h8000_0000, 32'h8000_0000);    // largest product
    push_op(F_LCM, 32'h8000_0000, 32'h7fff_ffff);
    push_op(F_LCM, -4, 6);
    push_op(F_LCM, 32'hffff_ffff, 32'hffff_ffff);
    push_op(F_INV, 3, 0);                            // modulus zero
    push_op(F_INV, 6, 9);                            // gcd not one
    push_op(F_INV, -1, 5);                           // signed gcd of minus one
    push_op(F_INV, 3, 7);
    push_op(F_INV, -3, 7);                           // negative coefficient lifted
    push_op(F_INV, 3, -7);                           // negative modulus
    push_op(F_INV, 32'h7fff_ffff, 32'h8000_0000);
    push_op(F_INV, 1134903170, 1836311903);
    push_op(F_INV, 1, 1);
    push_op(F_NOP, 32'hffff_ffff, 32'hffff_ffff);
    push_op(F_NOP, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      a = rand_operand();
      b = rand_operand();
      if ($urandom_range(0, 3) == 0) begin
        // shared factor so lcm and inverse take the interesting paths
        k = $urandom_range(2, 50);
        a = a * k;
        b = b * k;
      end
      if ($urandom_range(0, 19) == 0)
        push_op(F_NOP, a, b);
      else
        push_op(func_t'($urandom_range(0, 2)), a, b);
    end
    feed_done = 1'b1;
  end

  // driver: one beat at a time, random gap before each
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      func      <= '0;
      operand_a <= '0;
      operand_b <= '0;
      gap_left  <= 0;
    end else if (in_valid && !in_stall) begin
      // beat taken: either offer next directly or start a gap
      expected_answers.push_back(
        predict_answer(op_beat_t'{fn: func, a: operand_a, b: operand_b}));
      if (pending_ops.size() != 0 && $urandom_range(0, 3) == 0) begin
        func      <= pending_ops[0].fn;
        operand_a <= pending_ops[0].a;
        operand_b <= pending_ops[0].b;
        void'(pending_ops.pop_front());
      end else begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 3);
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        in_valid  <= 1'b1;
        func      <= pending_ops[0].fn;
        operand_a <= pending_ops[0].a;
        operand_b <= pending_ops[0].b;
        void'(pending_ops.pop_front());
      end
    end
  end

  // receiver: random stall per beat, one long hold-off early in the run
  int stall_left;
  int long_hold;
  int beats_seen;
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      long_hold  <= 0;
      beats_seen <= 0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= (long_hold > 1);
    end else if (out_valid && !out_stall) begin
      beats_seen <= beats_seen + 1;
      if (beats_seen == 30) begin
        // hold off long enough for the block to fill and stall its input
        long_hold  <= 8000;
        stall_left <= 0;
        out_stall  <= 1'b1;
      end else begin
        // wait drawn here is applied to the next result beat
        draw = $urandom_range(0, 3);
        stall_left <= draw;
        out_stall  <= (draw != 0);
      end
    end else if (out_valid && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else begin
      out_stall <= (stall_left > 0);
    end
  end

  // monitor: compare each result beat with the oldest expectation
  answer_t exp_ans;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result beat value=%0d flag=%0b",
                 $time, result_value, no_inverse);
        errors = errors + 1;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (result_value !== exp_ans.value) begin
          $display("%0t: result_value expected %0d actual %0d",
                   $time, $signed(exp_ans.value), result_value);
          errors = errors + 1;
        end
        if (no_inverse !== exp_ans.flag) begin
          $display("%0t: no_inverse expected %0b actual %0b",
                   $time, exp_ans.flag, no_inverse);
          errors = errors + 1;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (feed_done && pending_ops.size() == 0 && !in_valid
              && expected_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
          $display("PASS");
        else
          $display("FAIL");
        $finish;
      end
      begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    join
  end

endmodule
`default_nettype wire

// File: integer_gcd_lcm_modinv_unit.f
src/gcdu_pkg.sv
src/gcdu_div.sv
src/integer_gcd_lcm_modinv_unit.sv
tb/sv/tb_integer_gcd_lcm_modinv_unit.sv
